>>> design/tmur_pkg.sv
package tmur_pkg;

    localparam int SLOTS         = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 8;
    localparam int LEN_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam int MAP_DEPTH = 1 << ID_W;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int SLOT_DW   = PAYLOAD_WIDTH + LEN_W;

    localparam logic [ID_W-1:0]  FIRST_ID           = ID_W'(1);
    localparam logic [ID_W-1:0]  LAST_ID            = {ID_W{1'b1}};
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = CFG_W'(16);

    localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEREGISTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECEIVE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_USER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ID_W-1:0]          new_id;
        logic [PAYLOAD_WIDTH-1:0] payload;
        logic [LEN_W-1:0]         length;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_stat_t;

endpackage

>>> design/tagged_mailbox_with_user_registry_core.sv
// Mailbox of 16 packet slots with a registry of 8-bit user ids. After reset the
// block clears all 256 entries of the registry bitmap and holds in_stall high
// (configuration writes are taken throughout). Register, deregister, check and
// undefined commands pass from acceptance through the decide and done states
// to the output register. Send and receive scan the slots one per cycle
// through a single compare unit: a send stops at the lowest free slot, a hit
// is read out in the fetch state, and a receive miss scans the active slots
// (active_slots, clamped to 16). Bad user is reported in the decide state,
// full there or at the end of a send scan. One command is in flight at a
// time; the next word is taken once the result is in the output register.
module tagged_mailbox_with_user_registry_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tmur_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tmur_pkg::CMD_W-1:0]           command,
    input  logic [tmur_pkg::ID_W-1:0]            user_id,
    input  logic [tmur_pkg::PAYLOAD_WIDTH-1:0]   payload_in,
    input  logic [tmur_pkg::LEN_W-1:0]           length_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tmur_pkg::STATUS_W-1:0]        status,
    output logic [tmur_pkg::ID_W-1:0]            new_user_id,
    output logic [tmur_pkg::PAYLOAD_WIDTH-1:0]   payload_out,
    output logic [tmur_pkg::LEN_W-1:0]           length_out
);
    import tmur_pkg::*;

    logic [CFG_W-1:0] active_slots_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    ctrl_stat_t       stat;
    result_t          result;
    logic             out_free;
    logic             load;

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = stat.done && out_free;
    assign in_stall = !stat.idle;

    tmur_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .command      (command),
        .user_id      (user_id),
        .payload_in   (payload_in),
        .length_in    (length_in),
        .active_slots (active_slots_reg),
        .out_free     (out_free),
        .stat         (stat),
        .result       (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg <= ACTIVE_SLOTS_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_slots_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign new_user_id = out_reg.new_id;
    assign payload_out = out_reg.payload;
    assign length_out  = out_reg.length;

endmodule

>>> design/tmur_ram.sv
module tmur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/tmur_ctrl.sv
module tmur_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [tmur_pkg::CMD_W-1:0]           command,
    input  logic [tmur_pkg::ID_W-1:0]            user_id,
    input  logic [tmur_pkg::PAYLOAD_WIDTH-1:0]   payload_in,
    input  logic [tmur_pkg::LEN_W-1:0]           length_in,
    input  logic [tmur_pkg::CFG_W-1:0]           active_slots,
    input  logic                                 out_free,
    output tmur_pkg::ctrl_stat_t                 stat,
    output tmur_pkg::result_t                    result
);
    import tmur_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SEND   = 7'b0001000,
        S_RECV   = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]         cmd_reg;
    logic [ID_W-1:0]          uid_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [LEN_W-1:0]         len_reg;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [ID_W-1:0]  clr_reg, clr_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;
    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] occ_cnt_reg, occ_cnt_next;
    result_t          res_reg, res_next;

    logic [ID_W-1:0] dest_reg [SLOTS];
    logic            dest_we;

    logic             accept;
    logic [CNT_W-1:0] lim;
    logic [SLOT_W-1:0] sidx;

    logic            map_we;
    logic [ID_W-1:0] map_waddr;
    logic [0:0]      map_wdata;
    logic            map_re;
    logic [ID_W-1:0] map_raddr;
    logic [0:0]      map_rdata;

    logic               slot_we;
    logic               slot_re;
    logic [SLOT_DW-1:0] slot_rdata;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign sidx   = idx_reg[SLOT_W-1:0];

    // limit clamps to the built slot count
    always_comb
    begin
        if (32'(active_slots) > 32'(SLOTS))
        begin
            lim = CNT_W'(SLOTS);
        end
        else
        begin
            lim = CNT_W'(active_slots);
        end
    end

    tmur_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    tmur_ram #(.WIDTH(SLOT_DW), .DEPTH(SLOTS)) u_slot (
        .clk   (clk),
        .we    (slot_we),
        .waddr (sidx),
        .wdata ({pay_reg, len_reg}),
        .re    (slot_re),
        .raddr (sidx),
        .rdata (slot_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        clr_next     = clr_reg;
        next_id_next = next_id_reg;
        occ_next     = occ_reg;
        occ_cnt_next = occ_cnt_reg;
        res_next     = res_reg;
        dest_we      = 1'b0;
        map_we       = 1'b0;
        map_waddr    = uid_reg;
        map_wdata    = 1'b0;
        map_re       = 1'b0;
        map_raddr    = user_id;
        slot_we      = 1'b0;
        slot_re      = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + ID_W'(1);
                if (clr_reg == LAST_ID)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    map_re     = 1'b1;
                    res_next   = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_REGISTER:
                    begin
                        map_we          = 1'b1;
                        map_waddr       = next_id_reg;
                        map_wdata       = 1'b1;
                        res_next.new_id = next_id_reg;
                        next_id_next    = next_id_reg + ID_W'(1);
                    end
                    CMD_DEREGISTER:
                    begin
                        if (map_rdata[0])
                        begin
                            map_we = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_BAD_USER;
                        end
                    end
                    CMD_SEND:
                    begin
                        if (!map_rdata[0])
                        begin
                            res_next.status = ST_BAD_USER;
                        end
                        else if (occ_cnt_reg >= lim)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SEND;
                        end
                    end
                    CMD_RECEIVE:
                    begin
                        if (!map_rdata[0])
                        begin
                            res_next.status = ST_BAD_USER;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_RECV;
                        end
                    end
                    CMD_CHECK:
                    begin
                        if (!map_rdata[0])
                        begin
                            res_next.status = ST_BAD_USER;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SEND:
            begin
                // one slot per cycle, lowest free slot wins
                if (idx_reg >= lim)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end
                else if (!occ_reg[sidx])
                begin
                    occ_next[sidx] = 1'b1;
                    dest_we        = 1'b1;
                    slot_we        = 1'b1;
                    occ_cnt_next   = occ_cnt_reg + CNT_W'(1);
                    state_next     = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_RECV:
            begin
                if (idx_reg >= lim)
                begin
                    res_next.status = ST_NOTHING;
                    state_next      = S_DONE;
                end
                else if (occ_reg[sidx] && (dest_reg[sidx] == uid_reg))
                begin
                    occ_next[sidx] = 1'b0;
                    if (occ_cnt_reg != '0)
                    begin
                        occ_cnt_next = occ_cnt_reg - CNT_W'(1);
                    end
                    slot_re    = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_FETCH:
            begin
                res_next.payload = slot_rdata[SLOT_DW-1:LEN_W];
                res_next.length  = slot_rdata[LEN_W-1:0];
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            next_id_reg <= FIRST_ID;
            occ_reg     <= '0;
            occ_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            next_id_reg <= next_id_next;
            occ_reg     <= occ_next;
            occ_cnt_reg <= occ_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (accept)
        begin
            cmd_reg <= command;
            uid_reg <= user_id;
            pay_reg <= payload_in;
            len_reg <= length_in;
        end
        if (dest_we)
        begin
            dest_reg[sidx] <= uid_reg;
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign result    = res_reg;

endmodule
